// ===== hdl/dsv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes and helper functions for the date string validator.
// No dependencies; all files but the interfaces refer to it by scoped names.
package dsv_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_SLASH = 8'd47;

    localparam logic [2:0] SHORT_DIGITS_MAX = 3'd2;
    localparam logic [2:0] YEAR_DIGITS_MAX  = 3'd4;
    localparam logic [2:0] YEAR_DIGITS_SHORT = 3'd2;

    localparam logic [6:0] MONTH_FIRST = 7'd1;
    localparam logic [6:0] MONTH_LAST  = 7'd12;
    localparam logic [6:0] MONTH_FEB   = 7'd2;
    localparam logic [6:0] MONTH_APR   = 7'd4;
    localparam logic [6:0] MONTH_JUN   = 7'd6;
    localparam logic [6:0] MONTH_SEP   = 7'd9;
    localparam logic [6:0] MONTH_NOV   = 7'd11;

    localparam logic [4:0] DAYS_LONG  = 5'd31;
    localparam logic [4:0] DAYS_SHORT = 5'd30;
    localparam logic [4:0] DAYS_LEAP  = 5'd29;
    localparam logic [4:0] DAYS_FEB   = 5'd28;

    typedef enum logic [1:0] {
        PH_DAY   = 2'd0,
        PH_MONTH = 2'd1,
        PH_YEAR  = 2'd2
    } phase_t;

    // One parsed string, handed from the parser to the checker
    typedef struct packed {
        logic        malformed;
        logic [6:0]  day;
        logic [6:0]  month;
        logic [13:0] year;
        logic        year_len_ok;
        logic        century;     // year is a multiple of 100
        logic        hi_mod4_zero; // year / 100 is a multiple of 4
    } rec_t;

    function automatic logic [6:0] mac10_7(input logic [6:0] acc, input logic [3:0] dig);
        mac10_7 = {acc[3:0], 3'b000} + {acc[5:0], 1'b0} + {3'b000, dig};
    endfunction

    function automatic logic [13:0] mac10_14(input logic [13:0] acc, input logic [3:0] dig);
        mac10_14 = {acc[10:0], 3'b000} + {acc[12:0], 1'b0} + {10'd0, dig};
    endfunction

    function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
        if (m == MONTH_FEB)
        begin
            month_len = leap ? DAYS_LEAP : DAYS_FEB;
        end
        else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
        begin
            month_len = DAYS_SHORT;
        end
        else
        begin
            month_len = DAYS_LONG;
        end
    endfunction

endpackage

// ===== hdl/dsv_char_if.sv =====
`timescale 1ns / 1ps
// Character channel: one byte of the date string per request.
// No dependencies.
interface dsv_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink (input valid, input char_code, input last, output ready);
endinterface

// ===== hdl/dsv_res_if.sv =====
`timescale 1ns / 1ps
// Result channel: one verdict and the parsed date per string.
// No dependencies.
interface dsv_res_if;
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic signed [7:0]  day;
    logic signed [7:0]  month;
    logic signed [14:0] year;

    modport source (output valid, output valid_res, output day, output month, output year,
                    input ready);
    modport sink (input valid, input valid_res, input day, input month, input year,
                  output ready);
endinterface

// ===== hdl/dsv_front.sv =====
`timescale 1ns / 1ps
// Parser: takes one character per cycle when ready, builds day, month and year,
// and pushes one record per string to the queue. Uses dsv_pkg and dsv_char_if.
module dsv_front
(
    input  logic                clk,
    input  logic                rst_n,
    dsv_char_if.sink            char_in,
    input  logic                q_full,
    output logic                q_push,
    output dsv_pkg::rec_t       q_rec
);

    dsv_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  month_reg, month_next;
    logic [13:0] year_reg, year_next;
    logic [3:0]  ylast_reg, ylast_next;
    logic [3:0]  yprev_reg, yprev_next;
    logic [1:0]  hi4_reg, hi4_next;
    logic        bad_reg, bad_next;

    logic        fire;
    logic        is_dig;
    logic        is_slash;
    logic [3:0]  dval;

    assign char_in.ready = !q_full;
    assign fire = char_in.valid && char_in.ready;
    assign is_dig = (char_in.char_code >= dsv_pkg::CHAR_ZERO)
                 && (char_in.char_code <= dsv_pkg::CHAR_NINE);
    assign is_slash = (char_in.char_code == dsv_pkg::CHAR_SLASH);
    assign dval = char_in.char_code[3:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dsv_pkg::PH_DAY;
            cnt_reg   <= '0;
            day_reg   <= '0;
            month_reg <= '0;
            year_reg  <= '0;
            ylast_reg <= '0;
            yprev_reg <= '0;
            hi4_reg   <= '0;
            bad_reg   <= 1'b0;
        end
        else if (fire)
        begin
            if (char_in.last)
            begin
                phase_reg <= dsv_pkg::PH_DAY;
                cnt_reg   <= '0;
                day_reg   <= '0;
                month_reg <= '0;
                year_reg  <= '0;
                ylast_reg <= '0;
                yprev_reg <= '0;
                hi4_reg   <= '0;
                bad_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                day_reg   <= day_next;
                month_reg <= month_next;
                year_reg  <= year_next;
                ylast_reg <= ylast_next;
                yprev_reg <= yprev_next;
                hi4_reg   <= hi4_next;
                bad_reg   <= bad_next;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        ylast_next = ylast_reg;
        yprev_next = yprev_reg;
        hi4_next   = hi4_reg;
        bad_next   = bad_reg;
        if (!bad_reg)
        begin
            unique case (phase_reg)
                dsv_pkg::PH_DAY, dsv_pkg::PH_MONTH:
                begin
                    if (is_slash)
                    begin
                        if (cnt_reg == 3'd0)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = (phase_reg == dsv_pkg::PH_DAY) ? dsv_pkg::PH_MONTH
                                                                        : dsv_pkg::PH_YEAR;
                            cnt_next = '0;
                        end
                    end
                    else if (cnt_reg >= dsv_pkg::SHORT_DIGITS_MAX || !is_dig)
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        if (phase_reg == dsv_pkg::PH_DAY)
                        begin
                            day_next = dsv_pkg::mac10_7(day_reg, dval);
                        end
                        else
                        begin
                            month_next = dsv_pkg::mac10_7(month_reg, dval);
                        end
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                dsv_pkg::PH_YEAR:
                begin
                    if (cnt_reg < dsv_pkg::YEAR_DIGITS_MAX)
                    begin
                        if (is_dig)
                        begin
                            year_next  = dsv_pkg::mac10_14(year_reg, dval);
                            ylast_next = dval;
                            yprev_next = ylast_reg;
                            // hundreds part mod 4: (10*h + d) mod 4 = (2*h + d) mod 4
                            hi4_next   = {hi4_reg[0], 1'b0} + yprev_reg[1:0];
                            cnt_next   = cnt_reg + 3'd1;
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    bad_next = 1'b1;
                end
            endcase
        end
    end

    assign q_push = fire && char_in.last;

    always_comb
    begin
        q_rec.malformed    = bad_next || (phase_next != dsv_pkg::PH_YEAR);
        q_rec.day          = day_next;
        q_rec.month        = month_next;
        q_rec.year         = year_next;
        q_rec.year_len_ok  = (cnt_next == dsv_pkg::YEAR_DIGITS_SHORT)
                          || (cnt_next == dsv_pkg::YEAR_DIGITS_MAX);
        q_rec.century      = (ylast_next == 4'd0) && (yprev_next == 4'd0);
        q_rec.hi_mod4_zero = (hi4_next == 2'd0);
    end

endmodule

// ===== hdl/dsv_queue.sv =====
`timescale 1ns / 1ps
// Short record queue between parser and checker.
// Depends on dsv_pkg.
module dsv_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dsv_pkg::rec_t push_rec,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output dsv_pkg::rec_t pop_rec
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    dsv_pkg::rec_t slot_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_rec   = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PTR_LAST) ? '0 : wr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PTR_LAST) ? '0 : rd_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

// ===== hdl/dsv_back.sv =====
`timescale 1ns / 1ps
// Checker: takes one parsed record, checks year length, month and day against the
// calendar; holds the result in the output register. Uses dsv_pkg and dsv_res_if.
module dsv_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_not_empty,
    input  dsv_pkg::rec_t q_rec,
    output logic          q_pop,
    dsv_res_if.source     res_out
);

    logic               out_valid_reg;
    logic               vres_reg, vres_next;
    logic signed [7:0]  day_reg, day_next;
    logic signed [7:0]  month_reg, month_next;
    logic signed [14:0] year_reg, year_next;

    logic       leap;
    logic [4:0] mlen;
    logic       date_ok;

    assign q_pop = q_not_empty && (!out_valid_reg || res_out.ready);

    assign leap = (q_rec.year[1:0] == 2'b00) && (!q_rec.century || q_rec.hi_mod4_zero);
    assign mlen = dsv_pkg::month_len(q_rec.month, leap);
    assign date_ok = q_rec.year_len_ok
                  && (q_rec.month >= dsv_pkg::MONTH_FIRST)
                  && (q_rec.month <= dsv_pkg::MONTH_LAST)
                  && (q_rec.day != 7'd0)
                  && (q_rec.day <= {2'b00, mlen});

    always_comb
    begin
        if (q_rec.malformed)
        begin
            vres_next  = 1'b0;
            day_next   = '1;
            month_next = '1;
            year_next  = '1;
        end
        else
        begin
            vres_next  = date_ok;
            day_next   = {1'b0, q_rec.day};
            month_next = {1'b0, q_rec.month};
            year_next  = {1'b0, q_rec.year};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            vres_reg  <= vres_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
        end
    end

    assign res_out.valid     = out_valid_reg;
    assign res_out.valid_res = vres_reg;
    assign res_out.day       = day_reg;
    assign res_out.month     = month_reg;
    assign res_out.year      = year_reg;

endmodule

// ===== hdl/date_string_validator.sv =====
`timescale 1ns / 1ps
// Date string validator, d/m/y: one character accepted per cycle, back to back, while
// the queue has room. A string's record goes to the queue when its last character is
// accepted, then to the output register; one result per string. Throughput is set by the
// parser's per-character register update: one character a cycle while the queue has room.
// Reset (rst_n, asynchronous, active low) clears parser state, queue and output valid.
module date_string_validator
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    dsv_char_if.sink  char_in,
    dsv_res_if.source res_out
);

    logic          q_push, q_full, q_pop, q_not_empty;
    dsv_pkg::rec_t push_rec, pop_rec;

    dsv_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_rec   (push_rec)
    );

    dsv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_rec  (push_rec),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_rec   (pop_rec)
    );

    dsv_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_rec       (pop_rec),
        .q_pop       (q_pop),
        .res_out     (res_out)
    );

endmodule

// ===== tb/sv/tb_date_string_validator.sv =====
`timescale 1ns / 1ps
// Self-checking bench for date_string_validator: d/m/y strings go in a character at a time,
// each verdict is compared with an in-bench parser across several idle and stall phases.
// Depends on dsv_pkg, dsv_char_if, dsv_res_if and the date_string_validator RTL.
module tb_date_string_validator;

    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic               valid_res;
        logic signed [7:0]  day;
        logic signed [7:0]  month;
        logic signed [14:0] year;
    } date_verdict_t;

    logic clk;
    logic rst_n;

    dsv_char_if char_bus ();
    dsv_res_if  res_bus ();

    date_string_validator u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_bus),
        .res_out (res_bus)
    );

    date_verdict_t pending_verdicts[$];
    logic [7:0]    text_buf[$];
    int            fail_count;
    int            chars_sent;
    int            src_idle_pct;
    int            sink_stall_pct;

    dsv_pkg::phase_t parse_phase;
    logic [2:0]      digits_in_field;
    logic [6:0]      day_so_far;
    logic [6:0]      month_so_far;
    logic [13:0]     year_so_far;
    logic            string_broken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        if (m == dsv_pkg::MONTH_FEB)
        begin
            return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? dsv_pkg::DAYS_LEAP
                                                                         : dsv_pkg::DAYS_FEB;
        end
        if (m == dsv_pkg::MONTH_APR || m == dsv_pkg::MONTH_JUN || m == dsv_pkg::MONTH_SEP
            || m == dsv_pkg::MONTH_NOV)
        begin
            return dsv_pkg::DAYS_SHORT;
        end
        return dsv_pkg::DAYS_LONG;
    endfunction

    task automatic clear_parser();
        parse_phase     = dsv_pkg::PH_DAY;
        digits_in_field = 3'd0;
        day_so_far      = 7'd0;
        month_so_far    = 7'd0;
        year_so_far     = 14'd0;
        string_broken   = 1'b0;
    endtask

    task automatic parse_char(input logic [7:0] code, input logic is_last);
        logic          is_digit;
        logic [3:0]    dig;
        logic          ok;
        date_verdict_t verdict;
        is_digit = (code >= dsv_pkg::CHAR_ZERO) && (code <= dsv_pkg::CHAR_NINE);
        dig      = 4'(code - dsv_pkg::CHAR_ZERO);
        if (!string_broken)
        begin
            if (parse_phase == dsv_pkg::PH_DAY || parse_phase == dsv_pkg::PH_MONTH)
            begin
                if (code == dsv_pkg::CHAR_SLASH)
                begin
                    if (digits_in_field == 3'd0)
                    begin
                        string_broken = 1'b1;
                    end
                    else
                    begin
                        parse_phase     = (parse_phase == dsv_pkg::PH_DAY) ? dsv_pkg::PH_MONTH
                                                                           : dsv_pkg::PH_YEAR;
                        digits_in_field = 3'd0;
                    end
                end
                else if (digits_in_field >= dsv_pkg::SHORT_DIGITS_MAX || !is_digit)
                begin
                    string_broken = 1'b1;
                end
                else
                begin
                    if (parse_phase == dsv_pkg::PH_DAY)
                    begin
                        day_so_far = 7'(day_so_far * 10 + dig);
                    end
                    else
                    begin
                        month_so_far = 7'(month_so_far * 10 + dig);
                    end
                    digits_in_field++;
                end
            end
            else if (digits_in_field < dsv_pkg::YEAR_DIGITS_MAX)
            begin
                if (is_digit)
                begin
                    year_so_far = 14'(year_so_far * 10 + dig);
                    digits_in_field++;
                end
                else
                begin
                    string_broken = 1'b1;
                end
            end
        end
        if (is_last)
        begin
            if (string_broken || parse_phase != dsv_pkg::PH_YEAR)
            begin
                verdict.valid_res = 1'b0;
                verdict.day       = '1;
                verdict.month     = '1;
                verdict.year      = '1;
            end
            else
            begin
                ok = (digits_in_field == dsv_pkg::YEAR_DIGITS_SHORT)
                  || (digits_in_field == dsv_pkg::YEAR_DIGITS_MAX);
                if (month_so_far < dsv_pkg::MONTH_FIRST || month_so_far > dsv_pkg::MONTH_LAST)
                begin
                    ok = 1'b0;
                end
                else if (day_so_far < 1 || day_so_far > days_in_month(month_so_far, year_so_far))
                begin
                    ok = 1'b0;
                end
                verdict.valid_res = ok;
                verdict.day       = {1'b0, day_so_far};
                verdict.month     = {1'b0, month_so_far};
                verdict.year      = {1'b0, year_so_far};
            end
            pending_verdicts.push_back(verdict);
            clear_parser();
        end
    endtask

    task automatic send_char(input logic [7:0] code, input logic is_last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= code;
        char_bus.last      <= is_last;
        @(posedge clk);
        while (!char_bus.ready)
        begin
            @(posedge clk);
        end
        chars_sent++;
        parse_char(code, is_last);
    endtask

    task automatic send_text(input string s, input logic ends_string);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], ends_string && (i == s.len() - 1));
        end
    endtask

    task automatic send_buffer();
        for (int i = 0; i < text_buf.size(); i++)
        begin
            send_char(text_buf[i], i == text_buf.size() - 1);
        end
    endtask

    task automatic wait_for_results();
        char_bus.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic push_decimal(input int unsigned value, input int ndigits);
        for (int i = ndigits - 1; i >= 0; i--)
        begin
            text_buf.push_back(8'(dsv_pkg::CHAR_ZERO + (value / (10 ** i)) % 10));
        end
    endtask

    task automatic build_date();
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int          ylen;
        int unsigned sel;
        text_buf.delete();
        m   = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 12);
        sel = $urandom_range(9);
        if (sel < 6)
        begin
            ylen = 4;
            y    = $urandom_range(9999);
            if ($urandom_range(1) == 1)
            begin
                y = y - y % 4;
            end
            if ($urandom_range(3) == 0)
            begin
                y = y - y % 100;
            end
        end
        else if (sel < 9)
        begin
            ylen = 2;
            y    = $urandom_range(99);
        end
        else
        begin
            ylen = $urandom_range(2);
            if (ylen == 2)
            begin
                ylen = 3;
            end
            y = (ylen == 0) ? 0 : $urandom_range(10 ** ylen - 1);
        end
        case ($urandom_range(3))
            0:       d = days_in_month(m, y) + $urandom_range(1);
            1:       d = $urandom_range(99);
            default: d = $urandom_range(1, 28);
        endcase
        push_decimal(d, (d < 10 && $urandom_range(1) == 1) ? 1 : 2);
        text_buf.push_back(dsv_pkg::CHAR_SLASH);
        push_decimal(m, (m < 10 && $urandom_range(1) == 1) ? 1 : 2);
        text_buf.push_back(dsv_pkg::CHAR_SLASH);
        push_decimal(y, ylen);
        if (ylen == 4 && $urandom_range(4) == 0)
        begin
            repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic corrupt_date();
        int unsigned pos;
        pos = $urandom_range(text_buf.size() - 1);
        case ($urandom_range(3))
            0:       text_buf[pos] = 8'($urandom_range(255));
            1:       text_buf.delete(pos);
            2:       text_buf.insert(pos, dsv_pkg::CHAR_SLASH);
            default: while (text_buf.size() > pos + 1) text_buf.pop_back();
        endcase
        if (text_buf.size() == 0)
        begin
            text_buf.push_back(dsv_pkg::CHAR_SLASH);
        end
    endtask

    task automatic build_noise();
        text_buf.delete();
        repeat ($urandom_range(1, 10))
        begin
            if ($urandom_range(1) == 1)
            begin
                text_buf.push_back(($urandom_range(10) == 10)
                                   ? dsv_pkg::CHAR_SLASH
                                   : 8'(dsv_pkg::CHAR_ZERO + $urandom_range(9)));
            end
            else
            begin
                text_buf.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_field_extremes();
        send_char(8'h00, 1'b1);
        send_text("99/99/9999", 1'b0);
        send_char(8'hFF, 1'b1);
        wait_for_results();
    endtask

    task automatic test_malformed_strings();
        send_text("123", 1'b1);
        send_text("1//", 1'b1);
        wait_for_results();
    endtask

    task automatic test_year_rules();
        send_text("29/2/00", 1'b1);
        send_text("1/1/", 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_dates(input int src_pct, input int snk_pct, input int budget);
        int unsigned pick;
        int          target;
        src_idle_pct   = src_pct;
        sink_stall_pct = snk_pct;
        target         = chars_sent + budget;
        while (chars_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 88)
            begin
                build_date();
                if (pick >= 70)
                begin
                    corrupt_date();
                end
            end
            else
            begin
                build_noise();
            end
            send_buffer();
        end
        wait_for_results();
    endtask

    // Drive ready with random stalls
    initial
    begin
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        date_verdict_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result with no request outstanding: day %0d month %0d year %0d",
                       res_bus.day, res_bus.month, res_bus.year);
                fail_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (res_bus.valid_res !== want.valid_res)
                begin
                    $error("valid_res: expected %0d, got %0d", want.valid_res, res_bus.valid_res);
                    fail_count++;
                end
                if (res_bus.day !== want.day)
                begin
                    $error("day: expected %0d, got %0d", want.day, res_bus.day);
                    fail_count++;
                end
                if (res_bus.month !== want.month)
                begin
                    $error("month: expected %0d, got %0d", want.month, res_bus.month);
                    fail_count++;
                end
                if (res_bus.year !== want.year)
                begin
                    $error("year: expected %0d, got %0d", want.year, res_bus.year);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int stalled_cycles;
        stalled_cycles = 0;
        while (stalled_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((char_bus.valid && char_bus.ready) || (res_bus.valid && res_bus.ready))
            begin
                stalled_cycles = 0;
            end
            else if (pending_verdicts.size() != 0 || char_bus.valid)
            begin
                stalled_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        fail_count         = 0;
        chars_sent         = 0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        rst_n              <= 1'b0;
        char_bus.valid     <= 1'b0;
        char_bus.char_code <= 8'h00;
        char_bus.last      <= 1'b0;
        clear_parser();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_malformed_strings();
        test_year_rules();
        test_random_dates(0, 0, 320);
        test_random_dates(63, 0, 310);
        test_random_dates(0, 63, 310);
        test_random_dates(21, 21, 310);

        wait_for_results();
        repeat (8) @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            $error("%0d results never arrived", pending_verdicts.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== date_string_validator.f =====
hdl/dsv_pkg.sv
hdl/dsv_char_if.sv
hdl/dsv_res_if.sv
hdl/dsv_front.sv
hdl/dsv_queue.sv
hdl/dsv_back.sv
hdl/date_string_validator.sv
tb/sv/tb_date_string_validator.sv
